// ----- hw/rtl/gtm_pkg.sv -----
package gtm_pkg;

  localparam int unsigned NumChannels = 16;
  localparam int unsigned NumNotes    = 128;
  localparam int unsigned NoteW       = 7;
  localparam int unsigned VelW        = 7;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VELOCITY_MODE = 3'd0,
    CFG_NOTE_MAP_0    = 3'd1,
    CFG_NOTE_MAP_1    = 3'd2,
    CFG_NOTE_MAP_2    = 3'd3,
    CFG_NOTE_MAP_3    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_PANIC  = 1'b1
  } cmd_e;

  typedef logic [3:0][3:0][7:0] note_map_t;

  localparam note_map_t NoteMapReset = {
    32'h2726_2524, 32'h2B2A_2928, 32'h2F2E_2D2C, 32'h3332_3130
  };

  localparam logic [VelW-1:0]   GateVelocity   = 7'd100;
  localparam logic [VelW-1:0]   VelMax         = 7'd127;
  localparam logic signed [15:0] GateThreshMv  = 16'sd1000;
  // smallest voltage whose rounded velocity reaches the maximum
  localparam logic signed [15:0] VelClampMv    = 16'sd9961;
  localparam logic [20:0]       RoundBias      = 21'd5000;
  localparam logic [20:0]       VelScale       = 21'd127;
  // ceil(2^35 / 10000), exact quotient for numerators below 2^21
  localparam logic [42:0]       RecipMul       = 43'd3435974;
  localparam int unsigned       RecipShift     = 35;

endpackage

// ----- hw/rtl/gate_to_midi_note_events.sv -----
// Gate-to-MIDI note event converter.
// Input channel (in_valid_i / in_ready_o): one request per item, either a
// voltage sample for a gate channel (command_i = sample) or a panic for one
// note (command_i = panic, panic_note_i).
// Output channel (out_valid_o / out_ready_i): at most one note-on or
// note-off message per request; a sample with no gate edge gives nothing.
// Configuration: cfg_we_i writes register cfg_idx_i from cfg_wdata_i in the
// same edge (0 velocity mode, 1..4 note map words); write only while idle.
// Latency: a request taken at one edge sits in the input register, the gate
// bit read-modify-write and velocity scaling run from there, and the message
// shows in the output register at the next edge when the output is free.
// Throughput: one request per cycle while the output is not stalled.
// Stall: when out_ready_i is low with a message pending, the input register
// holds and in_ready_o drops once it is full; nothing is lost or repeated.
// Reset: all 128 gate bits low, velocity mode off, note map to its defaults,
// both registers empty.
module gate_to_midi_note_events
  import gtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [ChanW-1:0]    channel_i,
  input  logic signed [15:0]  voltage_mv_i,
  input  logic [NoteW-1:0]    panic_note_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_note_on_o,
  output logic [NoteW-1:0]    note_o,
  output logic [VelW-1:0]     velocity_o
);

  logic                vel_mode_q;
  note_map_t           map_q;
  logic [NumNotes-1:0] gate_q, gate_d;

  logic                s1_valid_q;
  logic                s1_cmd_q;
  logic [ChanW-1:0]    s1_chan_q;
  logic signed [15:0]  s1_mv_q;
  logic [NoteW-1:0]    s1_pnote_q;

  logic                out_valid_q, out_valid_d;
  logic                is_on_q, is_on_d;
  logic [NoteW-1:0]    note_q, note_d;
  logic [VelW-1:0]     vel_q, vel_d;

  logic                adv;
  logic [NoteW-1:0]    map_note;
  logic [VelW-1:0]     scaled_vel, cur_vel;
  logic [20:0]         num;
  logic [42:0]         prod;
  logic                cur_gate, last_gate;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_mode_q <= 1'b0;
      map_q      <= NoteMapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VELOCITY_MODE: vel_mode_q <= cfg_wdata_i[0];
        CFG_NOTE_MAP_0:    map_q[0]   <= cfg_wdata_i;
        CFG_NOTE_MAP_1:    map_q[1]   <= cfg_wdata_i;
        CFG_NOTE_MAP_2:    map_q[2]   <= cfg_wdata_i;
        CFG_NOTE_MAP_3:    map_q[3]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q   <= command_i;
      s1_chan_q  <= channel_i;
      s1_mv_q    <= voltage_mv_i;
      s1_pnote_q <= panic_note_i;
    end
  end

  // velocity scaling, round half up of mv*127/10000
  always_comb begin
    num  = 21'({7'd0, s1_mv_q[13:0]}) * VelScale + RoundBias;
    prod = 43'(num) * RecipMul;
    if (s1_mv_q[15] || (s1_mv_q == 16'sd0)) begin
      scaled_vel = '0;
    end else if (s1_mv_q >= VelClampMv) begin
      scaled_vel = VelMax;
    end else begin
      scaled_vel = prod[RecipShift +: VelW];
    end
  end

  always_comb begin
    map_note  = map_q[s1_chan_q[3:2]][s1_chan_q[1:0]][NoteW-1:0];
    if (vel_mode_q) begin
      cur_vel  = scaled_vel;
      cur_gate = (scaled_vel != '0);
    end else begin
      cur_vel  = GateVelocity;
      cur_gate = (s1_mv_q >= GateThreshMv);
    end
    last_gate = gate_q[map_note];

    gate_d      = gate_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_on_d     = is_on_q;
    note_d      = note_q;
    vel_d       = vel_q;

    if (adv) begin
      out_valid_d = 1'b0;
      if (s1_valid_q) begin
        case (s1_cmd_q)
          CMD_PANIC: begin
            gate_d[s1_pnote_q] = 1'b0;
            out_valid_d        = 1'b1;
            is_on_d            = 1'b0;
            note_d             = s1_pnote_q;
            vel_d              = '0;
          end
          CMD_SAMPLE: begin
            if (32'(s1_chan_q) < NumChannels) begin
              gate_d[map_note] = cur_gate;
              if (cur_gate != last_gate) begin
                out_valid_d = 1'b1;
                is_on_d     = cur_gate;
                note_d      = map_note;
                vel_d       = cur_vel;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gate_q      <= gate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_on_q <= is_on_d;
    note_q  <= note_d;
    vel_q   <= vel_d;
  end

  assign out_valid_o  = out_valid_q;
  assign is_note_on_o = is_on_q;
  assign note_o       = note_q;
  assign velocity_o   = vel_q;

  // a pending note-on or note-off agrees with the stored gate of its note
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && is_on_q |-> gate_q[note_q])
    else $error("note-on pending while gate bit is low");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !is_on_q |-> !gate_q[note_q])
    else $error("note-off pending while gate bit is high");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && adv && (s1_cmd_q == CMD_PANIC) |=>
      out_valid_q && !is_on_q && (vel_q == '0) && !gate_q[note_q])
    else $error("panic request did not give a zero note-off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free register");

endmodule

// ----- dv/gate_to_midi_note_events_checker.sv -----
`timescale 1ns / 1ps
module gate_to_midi_note_events_checker
  import gtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                command_i,
  input  logic [ChanW-1:0]    channel_i,
  input  logic signed [15:0]  voltage_mv_i,
  input  logic [NoteW-1:0]    panic_note_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                is_note_on_i,
  input  logic [NoteW-1:0]    note_i,
  input  logic [VelW-1:0]     velocity_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  typedef struct packed {
    logic            is_on;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
  } note_event_t;

  localparam int FullScaleMv = 10000;

  logic                velocity_mode_q;
  note_map_t           note_map_q;
  logic [NumNotes-1:0] gate_bits_q;
  note_event_t         expected_events[$];
  int unsigned         fails;
  int unsigned         checked;

  // rounded half away from zero, clamped to the midi range
  function automatic logic [VelW-1:0] scaled_velocity(input logic signed [15:0] mv);
    int num;
    if (mv <= 0) return '0;
    num = (int'(mv) * int'(VelMax) + FullScaleMv / 2) / FullScaleMv;
    if (num > int'(VelMax)) num = int'(VelMax);
    return VelW'(num);
  endfunction

  // updates the gate bits, returns 1 when the request yields a note message
  function automatic bit gate_event(input cmd_e cmd, input logic [ChanW-1:0] ch,
                                    input logic signed [15:0] mv,
                                    input logic [NoteW-1:0] pnote,
                                    output note_event_t ev);
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    logic             gate;
    logic             last;
    ev = '0;
    if (cmd == CMD_PANIC) begin
      gate_bits_q[pnote] = 1'b0;
      ev = '{is_on: 1'b0, note: pnote, vel: '0};
      return 1'b1;
    end
    if (ch >= NumChannels) return 1'b0;
    note = note_map_q[ch[3:2]][ch[1:0]][NoteW-1:0];
    if (velocity_mode_q) begin
      vel  = scaled_velocity(mv);
      gate = (vel != '0);
    end else begin
      vel  = GateVelocity;
      gate = (mv >= GateThreshMv);
    end
    last = gate_bits_q[note];
    gate_bits_q[note] = gate;
    if (gate == last) return 1'b0;
    ev = '{is_on: gate, note: note, vel: vel};
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    note_event_t seen;
    note_event_t want;
    note_event_t fresh;
    if (!rst_ni) begin
      velocity_mode_q = 1'b0;
      note_map_q      = NoteMapReset;
      gate_bits_q     = '0;
      expected_events.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{is_on: is_note_on_i, note: note_i, vel: velocity_i};
        if (expected_events.size() == 0) begin
          fails++;
          $error("unexpected note message: is_note_on %0b note %0d velocity %0d",
                 seen.is_on, seen.note, seen.vel);
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (seen.is_on !== want.is_on) begin
            fails++;
            $error("is_note_on: expected %0b, actual %0b", want.is_on, seen.is_on);
          end
          if (seen.note !== want.note) begin
            fails++;
            $error("note: expected %0d, actual %0d", want.note, seen.note);
          end
          if (seen.vel !== want.vel) begin
            fails++;
            $error("velocity: expected %0d, actual %0d", want.vel, seen.vel);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VELOCITY_MODE: velocity_mode_q = cfg_wdata_i[0];
          CFG_NOTE_MAP_0:    note_map_q[0] = cfg_wdata_i;
          CFG_NOTE_MAP_1:    note_map_q[1] = cfg_wdata_i;
          CFG_NOTE_MAP_2:    note_map_q[2] = cfg_wdata_i;
          CFG_NOTE_MAP_3:    note_map_q[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (gate_event(cmd_e'(command_i), channel_i, voltage_mv_i, panic_note_i, fresh))
          expected_events.push_back(fresh);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_events.size();
    checked_o    <= checked;
  end

endmodule

// ----- dv/gate_to_midi_note_events_test.sv -----
`timescale 1ns / 1ps
module gate_to_midi_note_events_test;
  import gtm_pkg::*;

  localparam int unsigned PhaseRequests = 255;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned QuietLimit    = 1000;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                command_i    = 1'b0;
  logic [ChanW-1:0]    channel_i    = '0;
  logic signed [15:0]  voltage_mv_i = '0;
  logic [NoteW-1:0]    panic_note_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                is_note_on_o;
  logic [NoteW-1:0]    note_o;
  logic [VelW-1:0]     velocity_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  bit                idle_on = 1'b0;
  logic              cur_mode = 1'b0;
  logic [3:0][31:0]  cur_map  = NoteMapReset;
  int unsigned       requests = 0;
  int unsigned       panics   = 0;
  int unsigned       settings = 1;
  int unsigned       stall_left = 0;
  int unsigned       quiet_cycles = 0;

  gate_to_midi_note_events DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .channel_i, .voltage_mv_i, .panic_note_i,
    .out_valid_o, .out_ready_i, .is_note_on_o, .note_o, .velocity_o
  );

  gate_to_midi_note_events_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .channel_i, .voltage_mv_i,
    .panic_note_i, .out_valid_i(out_valid_o), .out_ready_i,
    .is_note_on_i(is_note_on_o), .note_i(note_o), .velocity_i(velocity_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(1, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_request(input cmd_e cmd, input logic [ChanW-1:0] ch,
                             input logic signed [15:0] mv, input logic [NoteW-1:0] pnote);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    channel_i    <= ch;
    voltage_mv_i <= mv;
    panic_note_i <= pnote;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests++;
    if (cmd == CMD_PANIC) panics++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [3:0][31:0] words);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_VELOCITY_MODE;
    cfg_wdata_i <= 32'(mode);
    @(posedge clk_i);
    for (int k = 0; k < 4; k++) begin
      cfg_idx_i   <= cfg_idx_e'(CFG_NOTE_MAP_0 + k);
      cfg_wdata_i <= words[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_mode = mode;
    cur_map  = words;
    settings++;
  endtask

  // shared notes across channels and a random top bit per byte
  function automatic logic [31:0] random_map_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 1) == 0)
      for (int b = 0; b < 4; b++) w[8*b +: 7] = 7'(64 + $urandom_range(0, 3));
    return w;
  endfunction

  task automatic random_request();
    cmd_e               cmd;
    logic [ChanW-1:0]   ch;
    logic signed [15:0] mv;
    logic [NoteW-1:0]   pnote;
    cmd = ($urandom_range(0, 9) == 0) ? CMD_PANIC : CMD_SAMPLE;
    ch  = ChanW'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) pnote = NoteW'($urandom);
    else pnote = cur_map[ch[3:2]][{ch[1:0], 3'b000} +: NoteW];
    case ($urandom_range(0, 7))
      0, 1: mv = 16'($urandom_range(1000, 32767));
      2, 3: mv = 16'(int'($urandom_range(0, 33767)) - 32768);
      4:    mv = 16'($urandom_range(990, 1010));
      5:    mv = 16'(int'($urandom_range(0, 100)) - 20);
      6:    mv = 16'($urandom_range(0, 10100));
      default: mv = 16'($urandom);
    endcase
    put_request(cmd, ch, mv, pnote);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gate mode on the reset note map
    put_request(CMD_SAMPLE, 4'd0,  16'sd999,    7'd0);
    put_request(CMD_SAMPLE, 4'd0,  16'sd1000,   7'd0);
    put_request(CMD_SAMPLE, 4'd0,  16'sd32767,  7'd127);
    put_request(CMD_SAMPLE, 4'd0,  -16'sd32768, 7'd0);
    put_request(CMD_SAMPLE, 4'd15, 16'sd1000,   7'd0);
    put_request(CMD_PANIC,  4'd15, 16'sd32767,  7'h27);
    put_request(CMD_SAMPLE, 4'd15, 16'sd5000,   7'd0);
    put_request(CMD_PANIC,  4'd0,  16'sd0,      7'd0);
    put_request(CMD_PANIC,  4'd0,  -16'sd1,     7'd127);
    put_request(CMD_SAMPLE, 4'd15, -16'sd1,     7'd0);
    settle();

    // velocity mode, map bytes above 127 and channels sharing notes
    set_config(1'b1, {32'h7F7F_7F7F, 32'h8080_8080, 32'h0000_0000, 32'hFFFF_FFFF});
    put_request(CMD_SAMPLE, 4'd0,  16'sd39,     7'd0);
    put_request(CMD_SAMPLE, 4'd0,  16'sd40,     7'd0);
    put_request(CMD_SAMPLE, 4'd1,  16'sd9961,   7'd0);
    put_request(CMD_SAMPLE, 4'd0,  16'sd32767,  7'd0);
    put_request(CMD_SAMPLE, 4'd0,  -16'sd5,     7'd0);
    put_request(CMD_SAMPLE, 4'd4,  16'sd9960,   7'd0);
    put_request(CMD_SAMPLE, 4'd8,  -16'sd32768, 7'd0);
    put_request(CMD_SAMPLE, 4'd12, 16'sd9961,   7'd0);
    put_request(CMD_SAMPLE, 4'd13, 16'sd32767,  7'd0);
    put_request(CMD_PANIC,  4'd3,  16'sd1234,   7'd127);
    put_request(CMD_SAMPLE, 4'd0,  16'sd0,      7'd0);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_config(1'b0, '0);
        1: set_config(1'b1, '1);
        default: set_config(1'($urandom_range(0, 1)),
                            {random_map_word(), random_map_word(),
                             random_map_word(), random_map_word()});
      endcase
      idle_on = (p != 3) && (p != NumPhases - 1);
      repeat (PhaseRequests) random_request();
      settle();
    end

    $display("%0d requests sent (%0d panics) under %0d register settings",
             requests, panics, settings);
    $display("%0d note messages compared, last velocity mode %0b", checked, cur_mode);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
